// ----- hw/rtl/im2col_pkg.sv -----
package im2col_pkg;

	localparam int unsigned DefStoreDepth = 4096;
	localparam int unsigned DefDataWidth = 32;
	localparam int unsigned DefMaxOutWidth = 64;
	localparam int unsigned DefDilationRows = 1;
	localparam int unsigned DefDilationCols = 1;

	localparam int unsigned CfgIndexWidth = 3;
	localparam int unsigned CfgDataWidth = 7;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_IMAGE_HEIGHT = 3'd0,
		REG_IMAGE_WIDTH  = 3'd1,
		REG_KERNEL_WIDTH = 3'd2,
		REG_PAD_TOP      = 3'd3,
		REG_PAD_LEFT     = 3'd4,
		REG_PAD_RIGHT    = 3'd5,
		REG_STRIDE_ROWS  = 3'd6,
		REG_STRIDE_COLS  = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_EMIT = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [5:0]  channel;
		logic [5:0]  image_row;
		logic [5:0]  image_col;
		logic [31:0] pixel_value;
		logic [3:0]  tap_row;
		logic [3:0]  tap_col;
		logic [5:0]  out_row;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  out_col;
		logic        padded;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_ADDR_HI,
		ST_ADDR_LO,
		ST_WRITE,
		ST_RUN
	} state_t;

	function automatic logic [3:0] nonzero4(input logic [3:0] v);
		nonzero4 = (v == 4'd0) ? 4'd1 : v;
	endfunction

endpackage

// ----- hw/rtl/im2col_ram.sv -----
module im2col_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/im2col_line_generator_top.sv -----
// Column-matrix line generator for convolution by matrix product.
// Input items arrive on in_valid/in_stall with an in_data payload. A load item
// writes one pixel into the plane store at channel, row and column if these
// lie in the image and store, and gives no result. An emit item produces one
// line of the column matrix on out_valid/out_stall: one item per output
// column, the pixel, or zero where the padded position falls outside the image
// or store, with last set on the final one. Geometry is set through cfg_we,
// cfg_index and cfg_data; the user must set it only while the block idles, and
// the block itself does not enforce this. One shared multiply-add unit forms
// the row and store address of every item: a load in the two address states,
// an emit in the row state and both address states; the run state then issues
// one output item per cycle while the receiver does not stall, and each item
// is registered and appears in the cycle after it is issued. The input stalls
// from acceptance until the write of a load or the last item of an emit is
// issued; a result still waiting at the output does not block the next input
// item. When the receiver stalls, the output holds and no further store read
// is issued, so the line resumes where it stopped. Reset clears the sequencer,
// the output valid and the geometry registers to their defaults; the store
// itself is not cleared and every pixel must be loaded before it is read.
module im2col_line_generator_top #(
	parameter int unsigned STORE_DEPTH = im2col_pkg::DefStoreDepth,
	parameter int unsigned DATA_WIDTH = im2col_pkg::DefDataWidth,
	parameter int unsigned MAX_OUT_WIDTH = im2col_pkg::DefMaxOutWidth,
	parameter int unsigned DILATION_ROWS = im2col_pkg::DefDilationRows,
	parameter int unsigned DILATION_COLS = im2col_pkg::DefDilationCols
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [im2col_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [im2col_pkg::CfgDataWidth-1:0]   cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  im2col_pkg::in_item_t                  in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output im2col_pkg::out_item_t                 out_data
);

	import im2col_pkg::*;

	localparam int unsigned AddrWidth = $clog2(STORE_DEPTH);

	logic [6:0] height_q;
	logic [6:0] width_q;
	logic [3:0] kernel_w_q;
	logic [3:0] pad_top_q;
	logic [3:0] pad_left_q;
	logic [3:0] pad_right_q;
	logic [3:0] stride_r_q;
	logic [3:0] stride_c_q;

	state_t state_q, state_d;
	in_item_t item_q;

	logic [12:0]        mul_a;
	logic [6:0]         mul_b;
	logic signed [21:0] mul_c;
	logic [19:0]        mul_prod;
	logic signed [21:0] mul_res;
	logic               mul_en;
	logic signed [21:0] acc_q;

	logic               row_ok_q;
	logic signed [11:0] in_col_q;
	logic [9:0]         pos_q;
	logic [5:0]         k_q;

	logic [3:0]         stride_r;
	logic [3:0]         stride_c;
	logic [9:0]         ext;
	logic signed [9:0]  span;
	logic               span_neg;
	logic [10:0]        pos_next;
	logic               col_ok;
	logic               elem_ok;
	logic [22:0]        rd_addr_full;
	logic               in_store;
	logic               elem_last;
	logic               issue;
	logic               load_ok;

	logic                  ram_we;
	logic                  ram_re;
	logic [DATA_WIDTH-1:0] rd_data;

	logic       out_valid_q;
	logic [5:0] out_col_q;
	logic       out_padded_q;
	logic       out_last_q;
	logic       out_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 7'd1;
			width_q <= 7'd1;
			kernel_w_q <= 4'd1;
			pad_top_q <= 4'd0;
			pad_left_q <= 4'd0;
			pad_right_q <= 4'd0;
			stride_r_q <= 4'd1;
			stride_c_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_HEIGHT: height_q <= cfg_data[6:0];
				REG_IMAGE_WIDTH:  width_q <= cfg_data[6:0];
				REG_KERNEL_WIDTH: kernel_w_q <= cfg_data[3:0];
				REG_PAD_TOP:      pad_top_q <= cfg_data[3:0];
				REG_PAD_LEFT:     pad_left_q <= cfg_data[3:0];
				REG_PAD_RIGHT:    pad_right_q <= cfg_data[3:0];
				REG_STRIDE_ROWS:  stride_r_q <= cfg_data[3:0];
				REG_STRIDE_COLS:  stride_c_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign stride_r = nonzero4(stride_r_q);
	assign stride_c = nonzero4(stride_c_q);
	assign ext = 10'(DILATION_COLS * (nonzero4(kernel_w_q) - 4'd1)) + 10'd1;
	assign span = $signed(10'(width_q) + 10'(pad_left_q) + 10'(pad_right_q) - ext);
	assign span_neg = span[9];

	assign pos_next = {1'b0, pos_q} + 11'(stride_c);
	assign col_ok = !in_col_q[11] && (in_col_q < $signed({5'b0, width_q}));
	assign elem_ok = row_ok_q && col_ok;
	assign rd_addr_full = 23'(acc_q) + 23'(in_col_q);
	assign in_store = rd_addr_full < 23'(STORE_DEPTH);
	assign elem_last = (pos_next > {1'b0, span[9:0]}) || (k_q == 6'(MAX_OUT_WIDTH - 1));
	assign load_ok = ({1'b0, item_q.image_row} < height_q)
		&& ({1'b0, item_q.image_col} < width_q)
		&& !acc_q[21] && (acc_q[20:0] < 21'(STORE_DEPTH));

	assign mul_prod = 20'(mul_a * mul_b);
	assign mul_res = $signed({2'b0, mul_prod}) + mul_c;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.action == ACT_EMIT) ? ST_ROW : ST_ADDR_HI;
				end
			end
			ST_ROW:     state_d = ST_ADDR_HI;
			ST_ADDR_HI: state_d = ST_ADDR_LO;
			ST_ADDR_LO: state_d = (item_q.action == ACT_EMIT) ? ST_RUN : ST_WRITE;
			ST_WRITE:   state_d = ST_IDLE;
			ST_RUN: begin
				if (span_neg || (issue && elem_last)) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		mul_en = 1'b0;
		mul_a = '0;
		mul_b = '0;
		mul_c = '0;
		ram_we = 1'b0;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_ROW: begin
				mul_en = 1'b1;
				mul_a = 13'(item_q.out_row);
				mul_b = 7'(stride_r);
				mul_c = $signed(22'(item_q.tap_row * DILATION_ROWS))
					- $signed(22'(pad_top_q));
			end
			ST_ADDR_HI: begin
				mul_en = 1'b1;
				mul_a = 13'(item_q.channel);
				mul_b = height_q;
				mul_c = (item_q.action == ACT_EMIT) ? acc_q
					: $signed(22'(item_q.image_row));
			end
			ST_ADDR_LO: begin
				mul_en = 1'b1;
				mul_a = acc_q[12:0];
				mul_b = width_q;
				mul_c = (item_q.action == ACT_EMIT) ? 22'sd0
					: $signed(22'(item_q.image_col));
			end
			ST_WRITE: begin
				ram_we = load_ok;
			end
			ST_RUN: begin
				issue = !span_neg && (!out_valid_q || !out_stall);
			end
			default: begin
			end
		endcase
	end

	assign ram_re = issue && elem_ok && in_store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_data;
			in_col_q <= $signed(12'(in_data.tap_col * DILATION_COLS))
				- $signed(12'(pad_left_q));
			pos_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			in_col_q <= in_col_q + $signed(12'(stride_c));
			pos_q <= pos_next[9:0];
			k_q <= k_q + 6'd1;
		end
		if (mul_en) begin
			acc_q <= mul_res;
		end
		if (state_q == ST_ADDR_HI) begin
			row_ok_q <= !acc_q[21] && (acc_q < $signed({15'b0, height_q}));
		end
		if (issue) begin
			out_col_q <= k_q;
			out_padded_q <= !elem_ok;
			out_last_q <= elem_last;
			out_zero_q <= !(elem_ok && in_store);
		end
	end

	im2col_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(acc_q[AddrWidth-1:0]),
		.wdata(DATA_WIDTH'(item_q.pixel_value)),
		.re   (ram_re),
		.raddr(rd_addr_full[AddrWidth-1:0]),
		.rdata(rd_data)
	);

	assign out_valid = out_valid_q;
	assign out_data.value = out_zero_q ? 32'd0 : 32'(rd_data);
	assign out_data.out_col = out_col_q;
	assign out_data.padded = out_padded_q;
	assign out_data.last = out_last_q;

endmodule

// ----- bench/tb_im2col_line_generator_top.sv -----
module tb_im2col_line_generator_top;
	import im2col_pkg::*;

	localparam int DEPTH = DefStoreDepth;
	localparam int DIL_R = DefDilationRows;
	localparam int DIL_C = DefDilationCols;
	localparam int MAX_LINE = DefMaxOutWidth;
	localparam int PHASE_ITEMS = 60;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [6:0] h;
		logic [6:0] w;
		logic [3:0] kw;
		logic [3:0] pt;
		logic [3:0] pl;
		logic [3:0] pr;
		logic [3:0] sr;
		logic [3:0] sc;
	} geometry_t;

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t result;
	} plan_row_t;

	// The opening rows run with the reset geometry: one pixel per plane.
	localparam plan_row_t PLAN [15] = '{
		{ACT_LOAD, 6'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 4'd0, 4'd0, 6'd0, 1'b0, 40'd0},
		{ACT_EMIT, 6'd0, 6'd63, 6'd63, 32'h0, 4'd0, 4'd0, 6'd0,
			1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b1},
		{ACT_LOAD, 6'd0, 6'd0, 6'd0, 32'h0, 4'd14, 4'd14, 6'd63, 1'b0, 40'd0},
		{ACT_EMIT, 6'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 4'd0, 4'd0, 6'd0,
			1'b1, 32'h0, 6'd0, 1'b0, 1'b1},
		{ACT_LOAD, 6'd63, 6'd0, 6'd0, 32'hA5A5_5A5A, 4'd0, 4'd0, 6'd0, 1'b0, 40'd0},
		{ACT_EMIT, 6'd63, 6'd0, 6'd0, 32'h0, 4'd0, 4'd0, 6'd0,
			1'b1, 32'hA5A5_5A5A, 6'd0, 1'b0, 1'b1},
		{ACT_LOAD, 6'd1, 6'd63, 6'd63, 32'h1, 4'd0, 4'd0, 6'd0, 1'b0, 40'd0},
		{ACT_LOAD, 6'd1, 6'd0, 6'd63, 32'h2, 4'd0, 4'd0, 6'd0, 1'b0, 40'd0},
		{ACT_LOAD, 6'd1, 6'd63, 6'd0, 32'h3, 4'd0, 4'd0, 6'd0, 1'b0, 40'd0},
		{ACT_EMIT, 6'd0, 6'd0, 6'd0, 32'h0, 4'd14, 4'd0, 6'd0,
			1'b1, 32'h0, 6'd0, 1'b1, 1'b1},
		{ACT_EMIT, 6'd0, 6'd0, 6'd0, 32'h0, 4'd0, 4'd14, 6'd0,
			1'b1, 32'h0, 6'd0, 1'b1, 1'b1},
		{ACT_EMIT, 6'd0, 6'd0, 6'd0, 32'h0, 4'd0, 4'd0, 6'd63,
			1'b1, 32'h0, 6'd0, 1'b1, 1'b1},
		{ACT_EMIT, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF, 4'd14, 4'd14, 6'd63,
			1'b1, 32'h0, 6'd0, 1'b1, 1'b1},
		{ACT_LOAD, 6'd2, 6'd0, 6'd0, 32'h8000_0001, 4'd7, 4'd7, 6'd31, 1'b0, 40'd0},
		{ACT_EMIT, 6'd2, 6'd0, 6'd0, 32'h0, 4'd0, 4'd0, 6'd0, 1'b0, 40'd0}
	};

	localparam geometry_t SHAPES [8] = '{
		{7'd8, 7'd8, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
		{7'd64, 7'd64, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15},
		{7'd64, 7'd64, 4'd1, 4'd0, 4'd15, 4'd15, 4'd1, 4'd1},
		{7'd5, 7'd7, 4'd0, 4'd2, 4'd0, 4'd3, 4'd0, 4'd0},
		{7'd1, 7'd1, 4'd15, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1},
		{7'd12, 7'd20, 4'd5, 4'd3, 4'd2, 4'd2, 4'd2, 4'd3},
		{7'd16, 7'd32, 4'd2, 4'd0, 4'd1, 4'd0, 4'd3, 4'd1},
		{7'd1, 7'd64, 4'd1, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic [CfgDataWidth-1:0]  cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	in_item_t                 in_data = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	out_item_t                out_data;

	geometry_t                geo = {7'd1, 7'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1};
	logic [DefDataWidth-1:0]  pixel_mem [DEPTH];
	bit                       pixel_loaded [DEPTH];
	out_item_t                pending_elems [$];
	int                       landed_items = 0;
	int                       mismatches = 0;
	int                       gap_pct = 0;
	int                       stall_pct = 0;

	im2col_line_generator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic int at_least_one(input logic [3:0] v);
		return (v == 4'd0) ? 1 : int'(v);
	endfunction

	function automatic int line_length();
		int span;
		int n;
		span = int'(geo.w) + int'(geo.pl) + int'(geo.pr)
			- (DIL_C * (at_least_one(geo.kw) - 1) + 1);
		if (span < 0) begin
			return 0;
		end
		n = span / at_least_one(geo.sc) + 1;
		return (n > MAX_LINE) ? MAX_LINE : n;
	endfunction

	function automatic int src_row(input in_item_t it);
		return int'(it.out_row) * at_least_one(geo.sr) - int'(geo.pt)
			+ int'(it.tap_row) * DIL_R;
	endfunction

	function automatic int src_col(input in_item_t it, input int k);
		return k * at_least_one(geo.sc) - int'(geo.pl) + int'(it.tap_col) * DIL_C;
	endfunction

	function automatic bit in_image(input int r, input int c);
		return r >= 0 && r < int'(geo.h) && c >= 0 && c < int'(geo.w);
	endfunction

	function automatic int plane_addr(input int ch, input int r, input int c);
		return (ch * int'(geo.h) + r) * int'(geo.w) + c;
	endfunction

	function automatic void predict_line(input in_item_t it);
		int n;
		int r;
		int c;
		int a;
		out_item_t e;
		n = line_length();
		r = src_row(it);
		for (int k = 0; k < n; k++) begin
			c = src_col(it, k);
			e.value = '0;
			e.padded = 1'b1;
			if (in_image(r, c)) begin
				e.padded = 1'b0;
				a = plane_addr(int'(it.channel), r, c);
				if (a < DEPTH) begin
					e.value = pixel_mem[a];
				end
			end
			e.out_col = 6'(k);
			e.last = (k == n - 1);
			pending_elems.push_back(e);
		end
	endfunction

	function automatic void apply_item(input in_item_t it);
		int a;
		if (it.action == ACT_EMIT) begin
			predict_line(it);
			landed_items++;
		end else if (it.image_row < geo.h && it.image_col < geo.w) begin
			a = plane_addr(int'(it.channel), int'(it.image_row), int'(it.image_col));
			if (a < DEPTH) begin
				pixel_mem[a] = it.pixel_value;
				pixel_loaded[a] = 1'b1;
				landed_items++;
			end
		end
	endfunction

	function automatic in_item_t random_request();
		in_item_t it;
		int lim;
		it.action = ($urandom_range(0, 99) < 40) ? ACT_LOAD : ACT_EMIT;
		it.channel = 6'($urandom);
		it.image_row = 6'($urandom);
		it.image_col = 6'($urandom);
		it.pixel_value = $urandom;
		it.tap_row = 4'($urandom_range(0, 14));
		it.tap_col = 4'($urandom_range(0, 14));
		it.out_row = 6'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			it.channel = 6'($urandom_range(0, 3));
			if (it.action == ACT_LOAD) begin
				it.image_row = 6'($urandom_range(0, int'(geo.h) - 1));
				it.image_col = 6'($urandom_range(0, int'(geo.w) - 1));
			end else begin
				lim = (int'(geo.h) + int'(geo.pt)) / at_least_one(geo.sr);
				if (lim > 63) begin
					lim = 63;
				end
				it.out_row = 6'($urandom_range(0, lim));
				it.tap_col = 4'($urandom_range(0, at_least_one(geo.kw) - 1));
			end
		end
		return it;
	endfunction

	task automatic deliver(input in_item_t it);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_item(input in_item_t it);
		deliver(it);
		apply_item(it);
	endtask

	// Every pixel that a line reads inside the store is loaded first.
	task automatic fill_line(input in_item_t it);
		in_item_t ld;
		int n;
		int r;
		int c;
		int a;
		n = line_length();
		r = src_row(it);
		for (int k = 0; k < n; k++) begin
			c = src_col(it, k);
			if (in_image(r, c)) begin
				a = plane_addr(int'(it.channel), r, c);
				if (a < DEPTH && !pixel_loaded[a]) begin
					ld = random_request();
					ld.action = ACT_LOAD;
					ld.channel = it.channel;
					ld.image_row = 6'(r);
					ld.image_col = 6'(c);
					send_item(ld);
				end
			end
		end
	endtask

	task automatic settle(input int tail);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_elems.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [6:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_IMAGE_HEIGHT: geo.h = v;
			REG_IMAGE_WIDTH:  geo.w = v;
			REG_KERNEL_WIDTH: geo.kw = v[3:0];
			REG_PAD_TOP:      geo.pt = v[3:0];
			REG_PAD_LEFT:     geo.pl = v[3:0];
			REG_PAD_RIGHT:    geo.pr = v[3:0];
			REG_STRIDE_ROWS:  geo.sr = v[3:0];
			REG_STRIDE_COLS:  geo.sc = v[3:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input geometry_t g);
		write_reg(REG_IMAGE_HEIGHT, g.h);
		write_reg(REG_IMAGE_WIDTH, g.w);
		write_reg(REG_KERNEL_WIDTH, 7'(g.kw));
		write_reg(REG_PAD_TOP, 7'(g.pt));
		write_reg(REG_PAD_LEFT, 7'(g.pl));
		write_reg(REG_PAD_RIGHT, 7'(g.pr));
		write_reg(REG_STRIDE_ROWS, 7'(g.sr));
		write_reg(REG_STRIDE_COLS, 7'(g.sc));
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : check_output
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_elems.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected output item: value %h out_col %0d padded %b last %b",
						out_data.value, out_data.out_col, out_data.padded, out_data.last);
				end
			end else begin
				want = pending_elems.pop_front();
				if (out_data.value !== want.value || out_data.out_col !== want.out_col ||
						out_data.padded !== want.padded || out_data.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"line item mismatch: expected value %h col %0d pad %b",
							" last %b, got value %h col %0d pad %b last %b"},
							want.value, want.out_col, want.padded, want.last,
							out_data.value, out_data.out_col, out_data.padded,
							out_data.last);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb_im2col_line_generator_top failed");
		$finish;
	end

	initial begin : stimulus
		in_item_t it;
		int target;
		bit paused;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(PLAN); i++) begin
			deliver(PLAN[i].item);
			if (PLAN[i].typed) begin
				pending_elems.push_back(PLAN[i].result);
			end else begin
				apply_item(PLAN[i].item);
			end
		end
		settle(8);

		for (int p = 0; p < $size(SHAPES); p++) begin
			set_geometry(SHAPES[p]);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 45; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 45; end
				default: begin gap_pct = 20; stall_pct = 20; end
			endcase
			target = landed_items + PHASE_ITEMS;
			paused = 1'b0;
			while (landed_items < target) begin
				// The sender holds off now and then until the whole backlog has drained.
				if ((!paused && landed_items >= target - PHASE_ITEMS / 2) ||
						$urandom_range(0, 39) == 0) begin
					settle(1);
					paused = 1'b1;
				end
				it = random_request();
				if (it.action == ACT_EMIT) begin
					fill_line(it);
				end
				send_item(it);
			end
			settle(8);
		end

		gap_pct = 0;
		stall_pct = 0;
		settle(72);
		if (mismatches == 0 && pending_elems.size() == 0) begin
			$display("tb_im2col_line_generator_top passed");
		end else begin
			$display("tb_im2col_line_generator_top failed");
		end
		$finish;
	end

endmodule
